[rtl/core/rwms_pkg.sv]
// Shared widths, constants and payload types of the rolling window mean/std block.
package rwms_pkg;

   // Field widths of the channels
   localparam int SAMPLE_W = 24;
   localparam int MEAN_W   = 24;
   localparam int STD_W    = 23;

   // Running state widths, sized for windows of up to 64 samples
   localparam int SUM_W    = 31;
   localparam int SQ_W     = 53;
   localparam int NUM_W    = 64;

   // Variance quotient and its root
   localparam int VAR_W    = 48;
   localparam int ROOT_W   = VAR_W / 2;

   // Mean quotient width and the bias that keeps its dividend positive
   localparam int MQ_W            = 32;
   localparam int MEAN_BIAS_SHIFT = 30;

   // Quotient bits retired per divider cycle
   localparam int DIGIT_W = 4;

   localparam int STD_MAX        = (1 << STD_W) - 1;
   localparam int WINDOW_DEFAULT = 60;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] window_mean;
      logic [STD_W-1:0]         window_std;
   } rsp_payload_type;

endpackage

[rtl/core/rwms_chan_if.sv]
// Valid/ready stream channel carrying one payload per transfer.
interface rwms_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/rwms_div.sv]
// Digit-serial restoring divider by a constant, DIGIT_W quotient bits per cycle.
module rwms_div #(
   parameter int DIVISOR = 60,
   parameter int QUOT_W  = 32,
   parameter int DIGIT_W = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [QUOT_W+$clog2(DIVISOR+1)-1:0]   dividend,
   output logic                                  busy,
   output logic [QUOT_W-1:0]                     quotient
);
   localparam int DIV_W = $clog2(DIVISOR + 1);
   localparam int DVD_W = QUOT_W + DIV_W;
   localparam int STEPS = QUOT_W / DIGIT_W;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [DIV_W:0] DIVISOR_X = (DIV_W + 1)'(DIVISOR);
   localparam logic [CNT_W-1:0] STEPS_X = CNT_W'(STEPS);

   logic [DIV_W-1:0]  rem_ff, rem_in, rem_step;
   logic [QUOT_W-1:0] shift_ff, shift_in, shift_step;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_W:0]    trial;
   logic              fits;

   // Retire one digit: shift dividend bits into the remainder, subtract where it fits
   always_comb begin
      rem_step   = rem_ff;
      shift_step = shift_ff;
      trial      = '0;
      fits       = 1'b0;
      for (int i = 0; i < DIGIT_W; i++) begin
         trial      = {rem_step, shift_step[QUOT_W-1]};
         fits       = (trial >= DIVISOR_X);
         rem_step   = fits ? DIV_W'(trial - DIVISOR_X) : trial[DIV_W-1:0];
         shift_step = {shift_step[QUOT_W-2:0], fits};
      end
   end

   // Load on start, advance while busy
   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = dividend[DVD_W-1:QUOT_W];
         shift_in = dividend[QUOT_W-1:0];
         cnt_in   = STEPS_X;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = shift_step;
         cnt_in   = cnt_ff - 1'b1;
         busy_in  = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;
endmodule

[rtl/core/rwms_sqrt.sv]
// Bit-serial floor square root, two radicand bits per cycle.
module rwms_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rwms_pkg::VAR_W-1:0]   radicand,
   output logic                         busy,
   output logic [rwms_pkg::ROOT_W-1:0]  root
);
   import rwms_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [VAR_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [ROOT_W+2:0] rem_shift;
   logic [ROOT_W+2:0] trial;
   logic              fits;

   // Bring down the next bit pair and try root*4+1 against it
   assign rem_shift = {rem_ff, rad_ff[VAR_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[VAR_W-3:0], 2'b00};
         rem_in  = fits ? (ROOT_W + 1)'(rem_shift - trial) : rem_shift[ROOT_W:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

[rtl/core/rolling_window_mean_std_core.sv]
// Top level: sample ring, running sums, sequencer and result register.
//
//   channel   direction  payload                             transfer when
//   req_chan  in         sample (s24, 22 fraction bits)       valid && ready
//   rsp_chan  out        window_mean (s24), window_std (u23)  valid && ready
//
// While the window fills, an item only updates the sums and produces nothing.
// Once WINDOW samples are in, an item also forms the numerator, starts the dividers,
// waits for the 4-bit-per-cycle variance quotient (the mean quotient runs alongside)
// and the 24-step square root, and is handed off once the output register is free.
// Reset clears the sums, slot and fill count; the ring needs no clearing.
// A result waiting in the output register does not block the next sample.
module rolling_window_mean_std_core #(
   parameter int WINDOW = rwms_pkg::WINDOW_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   rwms_chan_if.sink    req_chan,
   rwms_chan_if.source  rsp_chan
);
   import rwms_pkg::*;

   localparam int ADDR_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int VDIV   = WINDOW * (WINDOW - 1);
   localparam int VDVD_W = VAR_W + $clog2(VDIV + 1);
   localparam int MDVD_W = MQ_W + $clog2(WINDOW + 1);
   localparam int SQR_W  = 2 * SAMPLE_W;
   localparam logic [ADDR_W-1:0] SLOT_LAST   = ADDR_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] WINDOW_FILL = FILL_W'(WINDOW);
   localparam logic [MDVD_W-1:0] MEAN_BIAS   = MDVD_W'(WINDOW) << MEAN_BIAS_SHIFT;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SQUARE = 8'b0000_0010,
      ST_UPDATE = 8'b0000_0100,
      ST_NUMER  = 8'b0000_1000,
      ST_LAUNCH = 8'b0001_0000,
      ST_DIVIDE = 8'b0010_0000,
      ST_ROOT   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [SAMPLE_W-1:0] old_ff;

   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                full_ff, full_in;
   logic [SAMPLE_W-1:0] x_ff, x_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]     sq_sum_ff, sq_sum_in;
   logic [SQR_W-1:0]    sq_new_ff, sq_new_in;
   logic [SQR_W-1:0]    sq_old_ff, sq_old_in;
   logic [2*SUM_W-1:0]  sum_sq_ff, sum_sq_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic                       accept;
   logic [SAMPLE_W-1:0]        old_masked;
   logic signed [SQR_W-1:0]    sq_new_full;
   logic signed [SQR_W-1:0]    sq_old_full;
   logic signed [2*SUM_W-1:0]  sum_sq_full;
   logic [MDVD_W-1:0]          mean_dvd;
   logic                       div_start;
   logic                       root_start;
   logic                       var_busy;
   logic                       mean_busy;
   logic                       root_busy;
   logic [VAR_W-1:0]           var_q;
   logic [MQ_W-1:0]            mean_q;
   logic [ROOT_W-1:0]          root_q;
   logic [STD_W-1:0]           std_val;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Store the new sample and read out the one it replaces
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[slot_ff] <= req_chan.payload.sample;
         old_ff            <= ring_mem[slot_ff];
      end
   end

   // Drop the oldest sample only when the ring was already full
   assign old_masked  = full_ff ? old_ff : '0;
   assign sq_new_full = $signed(x_ff) * $signed(x_ff);
   assign sq_old_full = $signed(old_masked) * $signed(old_masked);
   assign sum_sq_full = $signed(sum_ff) * $signed(sum_ff);

   // Bias the sum so that the unsigned quotient floors toward minus infinity
   assign mean_dvd = {{(MDVD_W - SUM_W){sum_ff[SUM_W-1]}}, sum_ff} + MEAN_BIAS;

   assign div_start  = (state_ff == ST_LAUNCH);
   assign root_start = (state_ff == ST_DIVIDE) && !var_busy && !mean_busy;

   // Clamp the root to the field range
   assign std_val = (root_q > ROOT_W'(STD_MAX)) ? STD_W'(STD_MAX) : root_q[STD_W-1:0];

   // Sequence one item through update and, once the window is full, divide and root
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      full_in      = full_ff;
      x_in         = x_ff;
      sum_in       = sum_ff;
      sq_sum_in    = sq_sum_ff;
      sq_new_in    = sq_new_ff;
      sq_old_in    = sq_old_ff;
      sum_sq_in    = sum_sq_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_chan.payload.sample;
               slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
               full_in  = (fill_ff == WINDOW_FILL);
               fill_in  = (fill_ff == WINDOW_FILL) ? fill_ff : fill_ff + 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sum_in    = sum_ff
                      - {{(SUM_W - SAMPLE_W){old_masked[SAMPLE_W-1]}}, old_masked}
                      + {{(SUM_W - SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
            sq_new_in = sq_new_full;
            sq_old_in = sq_old_full;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            sq_sum_in = sq_sum_ff - SQ_W'(sq_old_ff) + SQ_W'(sq_new_ff);
            sum_sq_in = sum_sq_full;
            state_in  = (fill_ff == WINDOW_FILL) ? ST_NUMER : ST_IDLE;
         end
         ST_NUMER: begin
            num_in   = NUM_W'(sq_sum_ff) * NUM_W'(WINDOW) - NUM_W'(sum_sq_ff);
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (root_start) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (!root_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in.window_mean = mean_q[MEAN_W-1:0];
               rsp_in.window_std  = std_val;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         sq_sum_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         sq_sum_ff    <= sq_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      sq_new_ff <= sq_new_in;
      sq_old_ff <= sq_old_in;
      sum_sq_ff <= sum_sq_in;
      num_ff    <= num_in;
      rsp_ff    <= rsp_in;
   end

   // Variance quotient: numerator over W*(W-1)
   rwms_div #(
      .DIVISOR (VDIV),
      .QUOT_W  (VAR_W),
      .DIGIT_W (DIGIT_W)
   ) u_var_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff[VDVD_W-1:0]),
      .busy     (var_busy),
      .quotient (var_q)
   );

   // Mean quotient: biased sum over W
   rwms_div #(
      .DIVISOR (WINDOW),
      .QUOT_W  (MQ_W),
      .DIGIT_W (DIGIT_W)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mean_dvd),
      .busy     (mean_busy),
      .quotient (mean_q)
   );

   rwms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (var_q),
      .busy     (root_busy),
      .root     (root_q)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SQUARE))
      else $error("accepted sample did not enter the update sequence");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WINDOW_FILL)
      else $error("fill count ran past the window");

   a_result_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NUMER) |-> (fill_ff == WINDOW_FILL))
      else $error("result computation started before the window filled");

   a_units_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (!var_busy && !mean_busy && !root_busy))
      else $error("result taken while an arithmetic unit was still busy");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid raised outside the hand-off state");
endmodule

[sim/rwms_window_checker.sv]
// Checker: models the rolling window mean/std and compares every result transfer.
module rwms_window_checker #(
   parameter int WINDOW = rwms_pkg::WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rwms_chan_if req_chan,
   rwms_chan_if rsp_chan,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import rwms_pkg::*;

   // Model of the block's window state
   logic signed [SAMPLE_W-1:0] window_ring [WINDOW];
   int unsigned                ring_slot;
   int unsigned                ring_fill;
   longint                     running_total;
   longint unsigned            running_squares;

   // Results predicted but not yet seen on the output channel
   rsp_payload_type            awaited_results [$];

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      error_count++;
   endtask

   // Floor square root, two bits of the radicand per step
   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n)
         probe >>= 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // Push one sample into the window; return 1 with the mean and std once it is full
   function automatic bit absorb_sample(input logic signed [SAMPLE_W-1:0] x,
                                        output rsp_payload_type result);
      longint          oldest;
      longint          mean_q;
      longint          total_mag;
      longint unsigned numer;
      longint unsigned variance_q;
      longint unsigned root;

      // Retire the oldest sample only once the ring is full
      if (ring_fill >= WINDOW) begin
         oldest           = longint'(window_ring[ring_slot]);
         running_total   -= oldest;
         running_squares -= longint'(oldest * oldest);
      end
      window_ring[ring_slot] = x;
      running_total   += longint'(x);
      running_squares += longint'(x) * longint'(x);

      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
      if (ring_fill < WINDOW)
         ring_fill++;
      result = '0;
      if (ring_fill < WINDOW)
         return 1'b0;

      // Mean rounds toward minus infinity
      mean_q = running_total / WINDOW;
      if (running_total < 0 && running_total % WINDOW != 0)
         mean_q--;

      total_mag  = (running_total < 0) ? -running_total : running_total;
      numer      = longint'(WINDOW) * running_squares - longint'(total_mag * total_mag);
      variance_q = numer / longint'(WINDOW * (WINDOW - 1));
      root       = floor_root(variance_q);
      if (root > STD_MAX)
         root = STD_MAX;

      result.window_mean = mean_q[MEAN_W-1:0];
      result.window_std  = root[STD_W-1:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type predicted;
      rsp_payload_type observed;
      rsp_payload_type oldest_wait;

      if (reset) begin
         ring_fill       = 0;
         ring_slot       = 0;
         running_total   = 0;
         running_squares = 0;
         awaited_results.delete();
         error_count     = 0;
      end else begin
         // Compare each result transfer with the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed = rsp_chan.payload;
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result mean %0d std %0d",
                                         observed.window_mean, observed.window_std));
            end else begin
               oldest_wait = awaited_results.pop_front();
               if (observed.window_mean !== oldest_wait.window_mean)
                  report_mismatch($sformatf("window_mean got %0d want %0d",
                                            observed.window_mean, oldest_wait.window_mean));
               if (observed.window_std !== oldest_wait.window_std)
                  report_mismatch($sformatf("window_std got %0d want %0d",
                                            observed.window_std, oldest_wait.window_std));
            end
         end

         // Advance the model on each sample transfer
         if (req_chan.valid && req_chan.ready) begin
            if (absorb_sample(req_chan.payload.sample, predicted))
               awaited_results.push_back(predicted);
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

[sim/tb_rolling_window_mean_std_core.sv]
// Testbench top: clock, reset, sample stimulus, result back-pressure and the verdict.
module tb_rolling_window_mean_std_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rwms_pkg::*;

   localparam int WINDOW          = WINDOW_DEFAULT;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int PHASE_COUNT     = 5;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 60;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   typedef enum int {
      RUN_FULL_RANGE,
      RUN_RAILS,
      RUN_ALTERNATE,
      RUN_CONSTANT,
      RUN_NEAR_ZERO,
      RUN_NEGATIVE
   } sample_run_type;

   logic clock = 1'b0;
   logic reset;

   int   req_idle_pct;
   int   rsp_stall_pct;
   int   hold_requests;
   int   error_count;
   int   pending_count;

   rwms_chan_if #(.payload_type(req_payload_type)) req_chan ();
   rwms_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   rolling_window_mean_std_core #(
      .WINDOW (WINDOW)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rwms_window_checker #(
      .WINDOW (WINDOW)
   ) mean_std_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Offer one sample, with random idle cycles ahead of it, and hold it until it transfers
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= x;
      do
         @(posedge clock);
      while (!req_chan.ready);
   endtask

   // Send a run of samples that share one random shape
   task automatic send_run(input int count);
      sample_run_type             shape;
      int                         pick;
      logic signed [SAMPLE_W-1:0] level;
      logic signed [SAMPLE_W-1:0] x;
      pick  = $urandom_range(0, 7);
      shape = (pick > 5) ? RUN_FULL_RANGE : sample_run_type'(pick);
      level = SAMPLE_W'($urandom());
      for (int i = 0; i < count; i++) begin
         case (shape)
            RUN_RAILS:     x = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            RUN_ALTERNATE: x = i[0] ? SAMPLE_MAX : SAMPLE_MIN;
            RUN_CONSTANT:  x = level;
            RUN_NEAR_ZERO: x = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            RUN_NEGATIVE:  x = {1'b1, 23'($urandom())};
            default:       x = SAMPLE_W'($urandom());
         endcase
         send_sample(x);
      end
   endtask

   // Result side: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Sample stimulus and verdict
   initial begin : sample_side
      logic signed [SAMPLE_W-1:0] edge_values [12];
      int phase_idle  [PHASE_COUNT];
      int phase_stall [PHASE_COUNT];
      int sent;
      int run_len;

      edge_values = '{24'sh000000, SAMPLE_MAX, SAMPLE_MIN, -24'sd1, 24'sd1,
                      24'sh555555, 24'shAAAAAA, 24'sh400000, -24'sh400000,
                      SAMPLE_MAX, SAMPLE_MIN, 24'sh000000};
      phase_idle  = '{0, 79,  0, 26, 0};
      phase_stall = '{0,  0, 79, 26, 0};

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_requests = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: rails, zero, unit steps and checkerboard patterns
      foreach (edge_values[i])
         send_sample(edge_values[i]);

      // Random runs under each idle/stall mix; the last phase starts with a long hold-off
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_idle_pct  = phase_idle[phase];
         rsp_stall_pct = phase_stall[phase];
         if (phase == PHASE_COUNT - 1)
            hold_requests++;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            run_len = $urandom_range(1, 120);
            if (run_len > ITEMS_PER_PHASE - sent)
               run_len = ITEMS_PER_PHASE - sent;
            send_run(run_len);
            sent += run_len;
         end
      end
      req_chan.valid <= 1'b0;

      // Drain outstanding results, then let the pipeline settle
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog
   initial begin
      #4ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
